>>> src/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the cordic sine/cosine pipeline
// Holds the Q32.32 vector type, the start gain and the arctangent table.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int DATA_W       = 64;
	localparam int TABLE_LEN    = 32;
	localparam int ITERATIONS_D = 32;

	// gain constant 0.60725... in Q32.32
	localparam logic signed [DATA_W-1:0] CORDIC_GAIN = 64'sd2608131496;

	// arctangent of 2^-i in Q32.32
	localparam logic [DATA_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
		64'd3373259426, 64'd1991351317, 64'd1052175346, 64'd534100634,
		64'd268086747,  64'd134174062,  64'd67103403,   64'd33553749,
		64'd16777130,   64'd8388597,    64'd4194302,    64'd2097151,
		64'd1048575,    64'd524287,     64'd262143,     64'd131071,
		64'd65536,      64'd32768,      64'd16384,      64'd8192,
		64'd4096,       64'd2048,       64'd1024,       64'd512,
		64'd256,        64'd128,        64'd64,         64'd32,
		64'd16,         64'd8,          64'd4,          64'd2
	};

	// rotating vector and residual angle carried from cell to cell
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} csc_vec_t;

endpackage

>>> src/cordic_sine_cosine.sv
// ----------------------------------------------------------------------------
// cordic_sine_cosine: Q32.32 sine and cosine by rotation-mode cordic
// Row of ITERATIONS registered rotation cells, one per iteration.
// ----------------------------------------------------------------------------
// an accepted transaction passes through the cell registers in order to done
// throughput: one transaction per cycle, set by one rotation cell per iteration
// busy stays low, results cannot be held off and show on done for one cycle
// reset clears the valid bit of every cell, payload is not reset
module cordic_sine_cosine
	import csc_pkg::*;
#(
	parameter int ITERATIONS = ITERATIONS_D
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] angle,
	output logic                     done,
	output logic signed [DATA_W-1:0] sine,
	output logic signed [DATA_W-1:0] cosine
);

	logic     vld [ITERATIONS+1];
	csc_vec_t vec [ITERATIONS+1];

	// pipeline always has room
	assign busy = 1'b0;

	// start vector of a new transaction
	assign vld[0]   = start && !busy;
	assign vec[0].x = CORDIC_GAIN;
	assign vec[0].y = '0;
	assign vec[0].z = angle;

	// chain of rotation cells
	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
		csc_cell #(
			.IDX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld[k]),
			.in_vec  (vec[k]),
			.out_vld (vld[k+1]),
			.out_vec (vec[k+1])
		);
	end

	// result ports straight from the last cell
	assign done   = vld[ITERATIONS];
	assign sine   = vec[ITERATIONS].y;
	assign cosine = vec[ITERATIONS].x;

	// an accepted transaction enters the first cell
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> vld[1])
		else $error("accepted transaction did not enter first cell");

	// valid bits advance one cell per cycle, none dropped or invented
	for (genvar k = 1; k < ITERATIONS; k++) begin : g_chk
		a_adv: assert property (@(posedge clk) disable iff (!arst_n)
			vld[k] |=> vld[k+1])
			else $error("transaction lost between cells");
		a_src: assert property (@(posedge clk) disable iff (!arst_n)
			(!vld[k] && $past(arst_n)) |=> !vld[k+1])
			else $error("transaction invented between cells");
	end

endmodule

>>> src/csc_cell.sv
// ----------------------------------------------------------------------------
// csc_cell: one cordic rotation step
// Rotates the vector by +/- atan(2^-IDX) steered by the sign of z and
// registers the result together with its valid bit.
// ----------------------------------------------------------------------------
module csc_cell
	import csc_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_vld,
	input  csc_vec_t in_vec,
	output logic     out_vld,
	output csc_vec_t out_vec
);

	localparam logic signed [DATA_W-1:0] ATAN_I = ATAN_TABLE[IDX];

	logic signed [DATA_W-1:0] xs;
	logic signed [DATA_W-1:0] ys;
	csc_vec_t                 nxt;
	logic                     vld_s1;
	csc_vec_t                 vec_s1;

	// shifted operands, constant shift per cell
	assign xs = in_vec.x >>> IDX;
	assign ys = in_vec.y >>> IDX;

	// rotate toward zero residual angle, sums wrap
	always_comb begin
		if (!in_vec.z[DATA_W-1]) begin
			nxt.x = in_vec.x - ys;
			nxt.y = in_vec.y + xs;
			nxt.z = in_vec.z - ATAN_I;
		end else begin
			nxt.x = in_vec.x + ys;
			nxt.y = in_vec.y - xs;
			nxt.z = in_vec.z + ATAN_I;
		end
	end

	// valid bit of this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		vec_s1 <= nxt;
	end

	assign out_vld = vld_s1;
	assign out_vec = vec_s1;

endmodule
